// ===== hw/rtl/fdmd_pkg.sv =====
// Shared types and constants for the frame difference motion detector.
// No dependencies; imported by every module of the block.
package fdmd_pkg;

	// Default frame store depth (pixels)
	localparam int MAX_PIXELS_DEF = 131072;

	// Field widths
	localparam int PIX_W  = 8;
	localparam int SUM_W  = 25;
	localparam int FPX_W  = 18;
	localparam int THR_W  = 8;
	localparam int CIDX_W = 2;

	// Saturation value of the running sum
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	// Register reset values
	localparam logic [FPX_W-1:0] FRAME_PIXELS_RST = FPX_W'(76800);
	localparam logic [THR_W-1:0] THRESHOLD_RST    = THR_W'(10);

	// Decoupling queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	// Register indexes
	typedef enum logic [CIDX_W-1:0] {
		CFG_FRAME_PIXELS = 2'd0,
		CFG_THRESHOLD    = 2'd1
	} cfg_idx_t;

	// One classified pixel handed from front to back
	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic [PIX_W-1:0] old_pixel;
		logic             last;
	} entry_t;

endpackage

// ===== hw/rtl/fdmd_front.sv =====
// Front end: pixel accept, frame position, frame store read-modify-write.
// Depends on fdmd_pkg.
module fdmd_front #(
	parameter int MAX_PIXELS = fdmd_pkg::MAX_PIXELS_DEF,
	parameter int AW         = $clog2(MAX_PIXELS),
	parameter int LW         = $clog2(MAX_PIXELS + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [fdmd_pkg::PIX_W-1:0] pixel,
	input  logic [LW-1:0]              frame_len,
	input  logic [fdmd_pkg::QCW-1:0]   q_count,
	output logic                       push,
	output fdmd_pkg::entry_t           push_entry
);
	import fdmd_pkg::*;

	logic [PIX_W-1:0] mem [MAX_PIXELS];

	logic [AW-1:0]    idx_q;
	logic [LW-1:0]    fill_q;
	logic             valid_s1;
	logic [PIX_W-1:0] pixel_s1;
	logic [PIX_W-1:0] rd_s1;
	logic             last_s1;
	logic             written_s1;
	logic             accept;
	logic             is_last;
	logic [LW-1:0]    idx_ext;
	logic [QCW:0]     used;

	// Credit: queue entries plus the request in the read stage
	assign used     = {1'b0, q_count} + {{QCW{1'b0}}, valid_s1};
	assign in_ready = used < (QCW+1)'(QDEPTH);
	assign accept   = in_valid && in_ready;

	assign idx_ext = {{(LW-AW){1'b0}}, idx_q};
	assign is_last = (idx_ext + LW'(1)) >= frame_len;

	// Frame store, read-first: old pixel out, new pixel in
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1       <= mem[idx_q];
			mem[idx_q]  <= pixel;
			pixel_s1    <= pixel;
			last_s1     <= is_last;
			written_s1  <= idx_ext < fill_q;
		end
	end

	// Frame position and fill mark; entries at or above the mark read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			fill_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				idx_q <= is_last ? '0 : idx_q + AW'(1);
				if (idx_ext >= fill_q) begin
					fill_q <= idx_ext + LW'(1);
				end
			end
		end
	end

	assign push                 = valid_s1;
	assign push_entry.pixel     = pixel_s1;
	assign push_entry.old_pixel = written_s1 ? rd_s1 : '0;
	assign push_entry.last      = last_s1;

`ifndef SYNTHESIS
	// The fill mark never passes the store depth
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= LW'(MAX_PIXELS))
		else $error("fill mark beyond frame store");
`endif

endmodule

// ===== hw/rtl/fdmd_queue.sv =====
// Short queue that decouples the front end from the accumulator.
// Depends on fdmd_pkg.
module fdmd_queue (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  fdmd_pkg::entry_t         push_entry,
	input  logic                     pop,
	output logic                     q_valid,
	output fdmd_pkg::entry_t         q_entry,
	output logic [fdmd_pkg::QCW-1:0] q_count
);
	import fdmd_pkg::*;

	entry_t         slot_q [QDEPTH];
	logic [QPW-1:0] wr_ptr_q;
	logic [QPW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPW'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPW'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCW'(1);
				2'b01:   count_q <= count_q - QCW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign q_valid = count_q != '0;
	assign q_entry = slot_q[rd_ptr_q];
	assign q_count = count_q;

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == QCW'(QDEPTH)) |-> !push)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("pop from empty queue");
	a_full_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == QCW'(QDEPTH)) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with count");
`endif

endmodule

// ===== hw/rtl/fdmd_back.sv =====
// Back end: absolute difference, saturating frame sum, threshold test, result register.
// Depends on fdmd_pkg.
module fdmd_back #(
	parameter int LIM_W = fdmd_pkg::THR_W + $clog2(fdmd_pkg::MAX_PIXELS_DEF + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	input  fdmd_pkg::entry_t           q_entry,
	output logic                       pop,
	input  logic [LIM_W-1:0]           limit,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       motion_flag,
	output logic [fdmd_pkg::SUM_W-1:0] difference_sum
);
	import fdmd_pkg::*;

	logic [SUM_W-1:0] run_q;
	logic             out_valid_q;
	logic             motion_q;
	logic [SUM_W-1:0] sum_out_q;
	logic [PIX_W-1:0] diff;
	logic [SUM_W:0]   sum_wide;
	logic [SUM_W-1:0] sum_next;

	// A frame's last pixel waits until the result register is free
	assign pop = q_valid && (!q_entry.last || !out_valid_q || out_ready);

	assign diff = (q_entry.pixel >= q_entry.old_pixel) ?
		(q_entry.pixel - q_entry.old_pixel) : (q_entry.old_pixel - q_entry.pixel);
	assign sum_wide = {1'b0, run_q} + {{(SUM_W+1-PIX_W){1'b0}}, diff};
	assign sum_next = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

	// Running sum and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				run_q <= q_entry.last ? '0 : sum_next;
			end
			if (pop && q_entry.last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (pop && q_entry.last) begin
			motion_q  <= 32'(sum_next) > 32'(limit);
			sum_out_q <= sum_next;
		end
	end

	assign out_valid      = out_valid_q;
	assign motion_flag    = motion_q;
	assign difference_sum = sum_out_q;

`ifndef SYNTHESIS
	a_sum_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && q_entry.last) |=> (run_q == '0))
		else $error("running sum not cleared at frame end");
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=>
		(out_valid_q && $stable(sum_out_q) && $stable(motion_q)))
		else $error("result dropped or changed while stalled");
`endif

endmodule

// ===== hw/rtl/frame_difference_motion_detect.sv =====
// Frame difference motion detector, top level: configuration registers and wiring.
// Depends on fdmd_pkg, fdmd_front, fdmd_queue, fdmd_back.
//
// Usage:
//   Pixel channel (in_valid/in_ready/pixel) takes one 8-bit gray pixel per
//   request in raster order. Each is compared with the stored pixel at the
//   same frame position; the stored pixel is then replaced.
//   Result channel (out_valid/out_ready) gives one request per frame:
//   motion_flag = difference_sum > threshold * frame length.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 is
//   the frame length in pixels, index 1 is the threshold; other indexes are
//   ignored. Write config only while the block is idle. cfg_ready is always high.
// Timing:
//   One pixel per cycle while in_ready is high, set by the single read-first port
//   of the frame store. out_valid rises once the frame's last pixel has passed the
//   read stage and queue into the result register. Untaken, that result holds the
//   next frame's last pixel; a four-entry queue then fills and in_ready drops.
// Reset:
//   The frame store reads as zero after reset via a fill mark, so the first
//   frame is compared against zeros; no clearing pass is needed.
module frame_difference_motion_detect #(
	parameter int MAX_PIXELS = fdmd_pkg::MAX_PIXELS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [fdmd_pkg::PIX_W-1:0]  pixel,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        motion_flag,
	output logic [fdmd_pkg::SUM_W-1:0]  difference_sum,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [fdmd_pkg::CIDX_W-1:0] cfg_index,
	input  logic [31:0]                 cfg_data
);
	import fdmd_pkg::*;

	localparam int AW    = $clog2(MAX_PIXELS);
	localparam int LW    = $clog2(MAX_PIXELS + 1);
	localparam int LIM_W = THR_W + LW;

	logic [FPX_W-1:0] frame_pixels_q;
	logic [THR_W-1:0] threshold_q;
	logic [LIM_W-1:0] limit_q;
	logic [LW-1:0]    frame_len;
	logic [31:0]      fp_ext;
	logic             push;
	entry_t           push_entry;
	logic             pop;
	logic             q_valid;
	entry_t           q_entry;
	logic [QCW-1:0]   q_count;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_pixels_q <= FRAME_PIXELS_RST;
			threshold_q    <= THRESHOLD_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_FRAME_PIXELS: frame_pixels_q <= cfg_data[FPX_W-1:0];
				CFG_THRESHOLD:    threshold_q    <= cfg_data[THR_W-1:0];
				default:          ;
			endcase
		end
	end

	// Effective frame length: zero means one, clamp to store depth
	assign fp_ext = 32'(frame_pixels_q);
	always_comb begin
		if (fp_ext == 32'd0) begin
			frame_len = LW'(1);
		end else if (fp_ext > 32'(MAX_PIXELS)) begin
			frame_len = LW'(MAX_PIXELS);
		end else begin
			frame_len = LW'(fp_ext);
		end
	end

	// Registered threshold * length
	always_ff @(posedge clk) begin
		limit_q <= LIM_W'(threshold_q) * LIM_W'(frame_len);
	end

	fdmd_front #(
		.MAX_PIXELS(MAX_PIXELS),
		.AW        (AW),
		.LW        (LW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pixel     (pixel),
		.frame_len (frame_len),
		.q_count   (q_count),
		.push      (push),
		.push_entry(push_entry)
	);

	fdmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.q_count   (q_count)
	);

	fdmd_back #(
		.LIM_W(LIM_W)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_entry       (q_entry),
		.pop           (pop),
		.limit         (limit_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.motion_flag   (motion_flag),
		.difference_sum(difference_sum)
	);

endmodule
